/* hdl/itra_pkg.sv */
// Shared types, constants and helpers for the integer-to-text converter.
package itra_pkg;

    // Configuration register indexes.
    localparam logic REG_RADIX     = 1'b0;
    localparam logic REG_MAX_CHARS = 1'b1;

    // Register widths and limits.
    localparam int RADIX_W   = 6;
    localparam int CHARS_W   = 7;
    localparam int CFG_W     = 7;
    localparam int CHAR_W    = 8;
    localparam int VALUE_W   = 64;
    localparam int STEP_BITS = 8;
    localparam int DIGIT_CAP = 64;
    localparam int PTR_W     = 6;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [CHARS_W-1:0] CHARS_RESET = 7'd64;
    localparam logic [CHARS_W-1:0] CHARS_MAX   = 7'd64;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_A     = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic div_step;
        logic push;
        logic rd;
        logic emit_sign;
        logic emit_ovf;
        logic emit_digit;
    } itra_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_last;
        logic q_zero;
        logic full;
        logic fits;
        logic negative;
        logic slot_free;
        logic last_digit;
    } itra_stat_t;

    // Map a digit value to its lower-case ASCII character.
    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        dx = CHAR_W'(d);
        if (d < 6'd10) begin
            return CHAR_ZERO + dx;
        end else begin
            return CHAR_A + dx - 8'd10;
        end
    endfunction

endpackage

/* hdl/itra_ctrl.sv */
// Controller state machine for the integer-to-text converter.
module itra_ctrl
    import itra_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  itra_stat_t stat,
    output itra_cmd_t  cmd
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_DIV   = 8'b0000_0010,
        ST_PUSH  = 8'b0000_0100,
        ST_CHECK = 8'b0000_1000,
        ST_OVF   = 8'b0001_0000,
        ST_SIGN  = 8'b0010_0000,
        ST_READ  = 8'b0100_0000,
        ST_EMIT  = 8'b1000_0000
    } itra_state_t;

    itra_state_t state_reg, state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                cmd.push = 1'b1;
                if (stat.q_zero || stat.full) begin
                    state_next = ST_CHECK;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_CHECK: begin
                priority if (!stat.fits) begin
                    state_next = ST_OVF;
                end else if (stat.negative) begin
                    state_next = ST_SIGN;
                end else begin
                    state_next = ST_READ;
                end
            end
            ST_OVF: begin
                if (stat.slot_free) begin
                    cmd.emit_ovf = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_SIGN: begin
                if (stat.slot_free) begin
                    cmd.emit_sign = 1'b1;
                    state_next    = ST_READ;
                end
            end
            ST_READ: begin
                cmd.rd     = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (stat.slot_free) begin
                    cmd.emit_digit = 1'b1;
                    state_next     = stat.last_digit ? ST_IDLE : ST_READ;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* hdl/itra_dp.sv */
// Datapath: configuration, chunked divider, digit stack and output register.
module itra_dp
    import itra_pkg::*;
#(
    parameter int VALUE_BITS = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic               cfg_index,
    input  logic [CFG_W-1:0]   cfg_wr_data,
    input  logic [VALUE_W-1:0] s_tdata,
    input  itra_cmd_t          cmd,
    output itra_stat_t         stat,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [CHAR_W-1:0]  m_tdata,
    output logic               m_tlast,
    output logic               m_tuser
);

    localparam int CHUNKS = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int DIV_W  = CHUNKS * STEP_BITS;
    localparam int CNT_W  = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CHUNKS - 1);

    logic [RADIX_W-1:0] radix_reg;
    logic [CHARS_W-1:0] cap_reg;
    logic [DIV_W-1:0]   q_reg;
    logic [RADIX_W-1:0] rem_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CHARS_W-1:0] ndig_reg;
    logic               neg_reg;
    logic [CHAR_W-1:0]  mem [DIGIT_CAP];
    logic [CHAR_W-1:0]  rdata_reg;
    logic               valid_reg;
    logic [CHAR_W-1:0]  data_reg;
    logic               last_reg;
    logic               user_reg;

    logic [VALUE_BITS-1:0] raw;
    logic [VALUE_BITS-1:0] mag;
    logic [RADIX_W-1:0]    rem_next;
    logic [STEP_BITS-1:0]  qbits;
    logic [RADIX_W:0]      trial;
    logic [CHAR_W-1:0]     total;
    logic [PTR_W-1:0]      rd_addr;
    logic                  emit_any;

    // Configuration registers, kept in their clamped form.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= RADIX_RESET;
            cap_reg   <= CHARS_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_RADIX: begin
                    if (cfg_wr_data[RADIX_W-1:0] < RADIX_MIN) begin
                        radix_reg <= RADIX_MIN;
                    end else if (cfg_wr_data[RADIX_W-1:0] > RADIX_MAX) begin
                        radix_reg <= RADIX_MAX;
                    end else begin
                        radix_reg <= cfg_wr_data[RADIX_W-1:0];
                    end
                end
                REG_MAX_CHARS: begin
                    cap_reg <= (cfg_wr_data > CHARS_MAX) ? CHARS_MAX : cfg_wr_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Sign and magnitude of the incoming value.
    assign raw = s_tdata[VALUE_BITS-1:0];
    assign mag = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;

    // Eight restoring division steps per cycle; the remainder stays below the radix.
    always_comb begin
        rem_next = rem_reg;
        qbits    = '0;
        trial    = '0;
        for (int i = 0; i < STEP_BITS; i++) begin
            trial = {rem_next, q_reg[DIV_W-1-i]};
            if (trial >= {1'b0, radix_reg}) begin
                rem_next           = RADIX_W'(trial - {1'b0, radix_reg});
                qbits[STEP_BITS-1-i] = 1'b1;
            end else begin
                rem_next = trial[RADIX_W-1:0];
            end
        end
    end

    // Dividend/quotient shift register, remainder, chunk and digit counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            ndig_reg <= '0;
        end else if (cmd.load) begin
            cnt_reg  <= '0;
            ndig_reg <= '0;
        end else if (cmd.div_step) begin
            cnt_reg <= (cnt_reg == CNT_LAST) ? '0 : cnt_reg + CNT_W'(1);
        end else if (cmd.push) begin
            ndig_reg <= ndig_reg + CHARS_W'(1);
        end else if (cmd.emit_digit) begin
            ndig_reg <= ndig_reg - CHARS_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            q_reg   <= DIV_W'(mag);
            rem_reg <= '0;
            neg_reg <= raw[VALUE_BITS-1];
        end else if (cmd.div_step) begin
            q_reg   <= DIV_W'({q_reg, qbits});
            rem_reg <= rem_next;
        end else if (cmd.push) begin
            rem_reg <= '0;
        end
    end

    // Digit stack: least significant digit written first, read back from the top.
    assign rd_addr = ndig_reg[PTR_W-1:0] - PTR_W'(1);

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            mem[ndig_reg[PTR_W-1:0]] <= digit_char(rem_reg);
        end
        if (cmd.rd) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Output register; it takes a new transaction when empty or being drained.
    assign emit_any = cmd.emit_sign | cmd.emit_ovf | cmd.emit_digit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (emit_any) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_ovf) begin
            data_reg <= CHAR_NUL;
            last_reg <= 1'b1;
            user_reg <= 1'b1;
        end else if (cmd.emit_sign) begin
            data_reg <= CHAR_MINUS;
            last_reg <= 1'b0;
            user_reg <= 1'b0;
        end else if (cmd.emit_digit) begin
            data_reg <= rdata_reg;
            last_reg <= (ndig_reg == CHARS_W'(1));
            user_reg <= 1'b0;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = user_reg;

    // Status back to the controller.
    assign total = CHAR_W'(ndig_reg) + CHAR_W'(neg_reg);

    assign stat.div_last   = (cnt_reg == CNT_LAST);
    assign stat.q_zero     = (q_reg == '0);
    assign stat.full       = (ndig_reg == CHARS_W'(DIGIT_CAP - 1));
    assign stat.fits       = (total <= CHAR_W'(cap_reg));
    assign stat.negative   = neg_reg;
    assign stat.slot_free  = !valid_reg || m_tready;
    assign stat.last_digit = (ndig_reg == CHARS_W'(1));

    // A result is only loaded when the output register can take it.
    a_emit_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_any |-> (!valid_reg || m_tready))
        else $error("result loaded over an untaken transaction");

    // The digit stack never grows past its depth.
    a_push_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |-> (ndig_reg < CHARS_W'(DIGIT_CAP)))
        else $error("digit stack overrun");

    // A digit is only emitted while the stack holds one.
    a_emit_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_digit |-> (ndig_reg != '0))
        else $error("digit emitted from an empty stack");

    // An overflow result is a lone, final, empty character.
    a_ovf_form: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_ovf |=> (m_tvalid && m_tlast && m_tuser && (m_tdata == CHAR_NUL)))
        else $error("malformed overflow result");

endmodule

/* hdl/int_to_radix_ascii.sv */
// Top level of the signed-integer to radix text converter.
//
//  Channel  Dir  Payload                                   Handshake
//  s_       in   tdata[63:0] = value (low VALUE_BITS used) tvalid/tready
//  m_       out  tdata[7:0] = char_code, tlast = last,     tvalid/tready
//                tuser = overflow
//  cfg_     in   cfg_index 0 = radix, 1 = max_chars        cfg_wr_en, no wait
//
//  With D digits and C = ceil(VALUE_BITS / 8), an item runs acceptance, D rounds of C divide
//  steps and a push, a check, then a read and an emit per digit; the shared divider retires
//  eight quotient bits a cycle. A leading minus sign adds one emit; an overflow result is a single emit.
//  Reset sets radix to 10 and the capacity to 64; no clearing pass is needed.
//  A stalled output holds the controller in the state that loads the next result; a new
//  item is taken once the last result of the previous one sits in the output register.
module int_to_radix_ascii
    import itra_pkg::*;
#(
    parameter int VALUE_BITS = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic               cfg_index,
    input  logic [CFG_W-1:0]   cfg_wr_data,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [VALUE_W-1:0] s_tdata,    // [63:0] value
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [CHAR_W-1:0]  m_tdata,    // [7:0] char_code
    output logic               m_tlast,
    output logic               m_tuser     // [0] overflow
);

    itra_cmd_t  cmd;
    itra_stat_t stat;

    // Sequencer.
    itra_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Divider, digit stack and output register.
    itra_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .cmd         (cmd),
        .stat        (stat),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

endmodule

/* sim/tb_int_to_radix_ascii.sv */
// Self-checking testbench for the signed integer to radix text converter.
`timescale 1ns / 100ps

module tb_int_to_radix_ascii;
    import itra_pkg::*;

    localparam int VALUE_BITS  = 64;
    localparam int HOLD_CYCLES = 3000;

    localparam logic [VALUE_W-1:0] MAX_POS = 64'h7fff_ffff_ffff_ffff;
    localparam logic [VALUE_W-1:0] MIN_NEG = 64'h8000_0000_0000_0000;

    // One character transaction as it leaves the block.
    typedef struct {
        logic [CHAR_W-1:0] char_code;
        logic              last;
        logic              overflow;
    } char_result_t;

    // Predicts the text of each accepted value and checks the characters against it.
    class text_scoreboard;
        logic [RADIX_W-1:0] radix_reg;
        logic [CHARS_W-1:0] cap_reg;
        char_result_t       pending_chars[$];
        int                 errors;
        string              digit_set;

        function new();
            radix_reg = RADIX_RESET;
            cap_reg   = CHARS_RESET;
            errors    = 0;
            digit_set = "0123456789abcdefghijklmnopqrstuvwxyz";
        endfunction

        function void write_config(input logic idx, input logic [CFG_W-1:0] data);
            if (idx == REG_RADIX) begin
                radix_reg = data[RADIX_W-1:0];
            end else begin
                cap_reg = data[CHARS_W-1:0];
            end
        endfunction

        // Work out every character that one value produces under the current setting.
        function void note_input(input logic [VALUE_W-1:0] value);
            logic [63:0]       mask;
            logic [63:0]       raw;
            logic [63:0]       mag;
            logic [63:0]       divisor;
            logic              negative;
            int                cap;
            int                ndig;
            int                total;
            logic [CHAR_W-1:0] digits[64];
            char_result_t      r;
            mask     = {64{1'b1}} >> (64 - VALUE_BITS);
            raw      = value & mask;
            negative = raw[VALUE_BITS-1];
            mag      = negative ? ((64'd0 - raw) & mask) : raw;
            divisor  = 64'(radix_reg);
            if (divisor < 2) divisor = 2;
            if (divisor > 36) divisor = 36;
            cap = int'(cap_reg);
            if (cap > DIGIT_CAP) cap = DIGIT_CAP;
            ndig = 0;
            do begin
                digits[ndig] = digit_set[int'(mag % divisor)];
                mag = mag / divisor;
                ndig++;
            end while (mag != 0 && ndig < 64);
            total = ndig + (negative ? 1 : 0);
            if (total > cap) begin
                r.char_code = CHAR_NUL;
                r.last      = 1'b1;
                r.overflow  = 1'b1;
                pending_chars.push_back(r);
                return;
            end
            r.overflow = 1'b0;
            if (negative) begin
                r.char_code = CHAR_MINUS;
                r.last      = 1'b0;
                pending_chars.push_back(r);
            end
            for (int i = ndig - 1; i >= 0; i--) begin
                r.char_code = digits[i];
                r.last      = (i == 0);
                pending_chars.push_back(r);
            end
        endfunction

        // Compare one output transaction with the oldest predicted character.
        function void check_result(input logic [CHAR_W-1:0] char_code, input logic last,
                                   input logic overflow);
            char_result_t exp_r;
            if (pending_chars.size() == 0) begin
                $error("unexpected character 0x%0h with nothing predicted", char_code);
                errors++;
                return;
            end
            exp_r = pending_chars.pop_front();
            if (char_code !== exp_r.char_code) begin
                $error("char_code mismatch: expected 0x%0h, actual 0x%0h",
                       exp_r.char_code, char_code);
                errors++;
            end
            if (last !== exp_r.last) begin
                $error("last mismatch: expected %0b, actual %0b", exp_r.last, last);
                errors++;
            end
            if (overflow !== exp_r.overflow) begin
                $error("overflow mismatch: expected %0b, actual %0b", exp_r.overflow, overflow);
                errors++;
            end
        endfunction

        function int pending();
            return pending_chars.size();
        endfunction
    endclass

    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic               cfg_index   = REG_RADIX;
    logic [CFG_W-1:0]   cfg_wr_data = '0;
    logic               s_tvalid    = 1'b0;
    logic               s_tready;
    logic [VALUE_W-1:0] s_tdata     = '0;
    logic               m_tvalid;
    logic               m_tready    = 1'b0;
    logic [CHAR_W-1:0]  m_tdata;
    logic               m_tlast;
    logic               m_tuser;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_request  = 0;
    int hold_seen     = 0;
    int hold_left     = 0;

    text_scoreboard sb = new();

    int_to_radix_ascii #(
        .VALUE_BITS (VALUE_BITS)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    always #1 aclk = ~aclk;

    // Receiver: random back-pressure, plus a long hold-off whenever one is requested.
    always @(posedge aclk) begin
        if (hold_seen != hold_request) begin
            hold_seen = hold_request;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Every character transaction goes to the scoreboard.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata, m_tlast, m_tuser);
        end
    end

    // Offer one value, with a random gap first, and wait until it is taken.
    task automatic send_value(input logic [VALUE_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(value);
    endtask

    // Drain the block, then write both registers.
    task automatic set_config(input logic [CFG_W-1:0] radix, input logic [CFG_W-1:0] cap);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= REG_RADIX;
        cfg_wr_data <= radix;
        @(posedge aclk);
        sb.write_config(REG_RADIX, radix);
        cfg_index   <= REG_MAX_CHARS;
        cfg_wr_data <= cap;
        @(posedge aclk);
        sb.write_config(REG_MAX_CHARS, cap);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly short values so that runs stay quick, some full-width and some extremes.
    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] v;
        int                 pick;
        int                 nbits;
        v    = {$urandom, $urandom};
        pick = $urandom_range(9);
        if (pick >= 3 && pick <= 8) begin
            nbits = $urandom_range(1, 20);
            v = v & ((64'd1 << nbits) - 1);
            if ($urandom_range(1)) v = -v;
        end else if (pick == 9) begin
            case ($urandom_range(4))
                0: v = MAX_POS;
                1: v = MIN_NEG;
                2: v = -MAX_POS;
                3: v = '0;
                default: v = {64{1'b1}};
            endcase
        end
        return v;
    endfunction

    function automatic logic [CFG_W-1:0] random_radix();
        if ($urandom_range(9) < 8) return CFG_W'($urandom_range(2, 36));
        return CFG_W'($urandom_range(0, 63));
    endfunction

    function automatic logic [CFG_W-1:0] random_cap();
        int pick;
        pick = $urandom_range(9);
        if (pick < 5) return CFG_W'(DIGIT_CAP);
        if (pick < 8) return CFG_W'($urandom_range(1, 64));
        return CFG_W'($urandom_range(0, 127));
    endfunction

    // Main sequence: reset, directed cases, then random phases with changing idling.
    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 6;
        recv_idle_pct = 45;

        // Reset setting: decimal, full capacity.
        send_value('0);
        send_value(64'd1);
        send_value({64{1'b1}});
        send_value(64'd9);
        send_value(64'd10);
        send_value(MAX_POS);
        send_value(MIN_NEG);
        send_value(-MAX_POS);

        // Binary: the most negative value needs one character too many.
        set_config(7'd2, 7'd64);
        send_value(MAX_POS);
        send_value(MIN_NEG);
        send_value(-MAX_POS);
        send_value(64'd5);

        // Base 36 covers the top digit.
        set_config(7'd36, 7'd64);
        send_value(64'd35);
        send_value(64'd36);
        send_value(-64'd1295);

        // Hex with capacity exactly at and just below the text length.
        set_config(7'd16, 7'd17);
        send_value(MIN_NEG);
        set_config(7'd16, 7'd16);
        send_value(MIN_NEG);
        send_value(MAX_POS);

        // Radix below two and a single-character capacity.
        set_config(7'd1, 7'd1);
        send_value('0);
        send_value(64'd1);
        send_value({64{1'b1}});

        // Radix above the top and zero capacity.
        set_config(7'd63, 7'd0);
        send_value('0);
        send_value(64'd35);

        // Radix zero and capacity above the top.
        set_config(7'd0, 7'd127);
        send_value(-MAX_POS);
        send_value(MIN_NEG);

        // Random phases.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 6;
                    recv_idle_pct = 45;
                end
                1: begin
                    send_idle_pct = 45;
                    recv_idle_pct = 6;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < 117; n++) begin
                if (n % 25 == 0) begin
                    set_config(random_radix(), random_cap());
                    // The receiver stalls for a long stretch while values keep coming.
                    if (phase == 2 && n == 0) hold_request++;
                end
                send_value(random_value());
            end
        end

        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("tb_int_to_radix_ascii: PASS");
        end else begin
            $display("tb_int_to_radix_ascii: FAIL");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #20_000_000;
        $display("tb_int_to_radix_ascii: FAIL");
        $finish;
    end

endmodule
